// ===== rtl/enp_pkg.sv =====
package enp_pkg;

	localparam int unsigned ALIGN_BYTES = 4;
	localparam int unsigned HEADER_BYTES = 12;
	localparam int unsigned INT_MAX_BYTES = 8;
	localparam logic [23:0] OWNER_GNU = 24'h554E47;
	localparam logic [31:0] OWNER_CORE = 32'h45524F43;

	typedef enum logic [1:0] {
		REG_NAME_LIMIT   = 2'd0,
		REG_DATA_LIMIT   = 2'd1,
		REG_RECORD_LIMIT = 2'd2,
		REG_BIG_ENDIAN   = 2'd3
	} reg_index_t;

	typedef enum logic {
		ITEM_START = 1'b0,
		ITEM_BYTE  = 1'b1
	} item_kind_t;

	typedef enum logic [1:0] {
		RES_NOTE   = 2'd0,
		RES_FINISH = 2'd1,
		RES_ERROR  = 2'd2
	} res_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_LIMIT     = 2'd1,
		ERR_TRUNCATED = 2'd2,
		ERR_OWNER     = 2'd3
	} err_code_t;

	typedef enum logic [1:0] {
		VAL_INT   = 2'd0,
		VAL_TEXT  = 2'd1,
		VAL_BYTES = 2'd2
	} val_kind_t;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_HEADER   = 7'b0000010,
		PH_NAME     = 7'b0000100,
		PH_NAME_PAD = 7'b0001000,
		PH_DESC     = 7'b0010000,
		PH_DESC_PAD = 7'b0100000,
		PH_DONE     = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [31:0] name_limit;
		logic [31:0] data_limit;
		logic [31:0] record_limit;
		logic        big_endian;
	} cfg_t;

	typedef struct packed {
		logic [63:0] integer_value;
		logic [1:0]  val_kind;
		logic [31:0] descriptor_length;
		logic [31:0] owner_length;
		logic [31:0] note_type;
		logic [31:0] offset;
		logic [1:0]  error_code;
		logic [1:0]  result_kind;
	} result_t;

	typedef struct packed {
		logic [1:0]       n;
		result_t [1:0]    r;
	} res_pair_t;

	function automatic logic [31:0] pad_of(input logic [31:0] x);
		logic [31:0] neg;
		neg = ~x + 32'd1;
		return neg & 32'(ALIGN_BYTES - 1);
	endfunction

	function automatic logic byte_ok(input logic [7:0] b);
		return (b >= 8'h20 && b <= 8'h7E) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

endpackage

// ===== rtl/enp_cfg.sv =====
module enp_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output enp_pkg::cfg_t      cfg
);
	import enp_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.name_limit   <= 32'd4096;
			cfg_q.data_limit   <= 32'd16777216;
			cfg_q.record_limit <= 32'd65536;
			cfg_q.big_endian   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (reg_index_t'(cfg_index))
				REG_NAME_LIMIT:   cfg_q.name_limit <= cfg_data;
				REG_DATA_LIMIT:   cfg_q.data_limit <= cfg_data;
				REG_RECORD_LIMIT: cfg_q.record_limit <= cfg_data;
				REG_BIG_ENDIAN:   cfg_q.big_endian <= cfg_data[0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

// ===== rtl/enp_core.sv =====
module enp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  enp_pkg::cfg_t        cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_kind,
	input  logic [31:0]          in_length,
	input  logic [7:0]           in_byte,
	input  logic                 can_load,
	output logic                 pair_valid,
	output enp_pkg::res_pair_t   pair
);
	import enp_pkg::*;

	logic        valid_s1;
	item_kind_t  kind_s1;
	logic [31:0] len_s1;
	logic [7:0]  byte_s1;
	logic        fire;

	phase_t      ph_q, nx_ph;
	logic [31:0] pos_q, nx_pos;
	logic [31:0] len_q, nx_len;
	logic [31:0] rs_q, nx_rs;
	logic [31:0] fc_q, nx_fc;
	logic [31:0] hw_q, nx_hw;
	logic [31:0] own_q, nx_own;
	logic [31:0] vs_q, nx_vs;
	logic [31:0] type_q, nx_type;
	logic [31:0] oh_q, nx_oh;
	logic [31:0] trim_q, nx_trim;
	logic [1:0]  tf_q, nx_tf;
	logic [63:0] va_q, nx_va;
	logic [31:0] cnt_q, nx_cnt;

	logic [1:0]  nx_n;
	result_t     res_a [2];
	logic        begin_note;
	logic [31:0] hw_new, rem, after, pad_own, pad_vs;
	logic        gnu, core;

	assign fire = valid_s1 && can_load;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1 <= item_kind_t'(in_kind);
			len_s1  <= in_length;
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		nx_ph = ph_q; nx_pos = pos_q; nx_len = len_q; nx_rs = rs_q; nx_fc = fc_q;
		nx_hw = hw_q; nx_own = own_q; nx_vs = vs_q; nx_type = type_q; nx_oh = oh_q;
		nx_trim = trim_q; nx_tf = tf_q; nx_va = va_q; nx_cnt = cnt_q;
		nx_n = 2'd0;
		res_a[0] = '0;
		res_a[1] = '0;
		begin_note = 1'b0;
		hw_new = '0;
		rem = '0;
		after = '0;
		pad_own = '0;
		pad_vs = '0;
		gnu = 1'b0;
		core = 1'b0;
		if (fire) begin
			if (kind_s1 == ITEM_START) begin
				nx_pos = '0;
				nx_cnt = '0;
				nx_len = len_s1;
				nx_rs = '0;
				if (len_s1 > cfg.data_limit) begin
					res_a[0].result_kind = RES_ERROR;
					res_a[0].error_code = ERR_LIMIT;
					nx_n = 2'd1;
					nx_ph = PH_DONE;
				end else begin
					begin_note = 1'b1;
				end
			end else if (ph_q != PH_IDLE && ph_q != PH_DONE) begin
				nx_pos = pos_q + 32'd1;
				nx_fc = fc_q + 32'd1;
				// byte lands in the field of the current phase
				if (ph_q == PH_HEADER) begin
					if (cfg.big_endian)
						hw_new = {hw_q[23:0], byte_s1};
					else
						hw_new = hw_q | (32'(byte_s1) << {fc_q[1:0], 3'b000});
					nx_hw = hw_new;
					if (fc_q[1:0] == 2'd3) begin
						if (fc_q == 32'd3) nx_own = hw_new;
						else if (fc_q == 32'd7) nx_vs = hw_new;
						else nx_type = hw_new;
						nx_hw = '0;
					end
				end else if (ph_q == PH_NAME) begin
					if (fc_q < 32'd4)
						nx_oh = oh_q | (32'(byte_s1) << {fc_q[1:0], 3'b000});
					if (byte_s1 != 8'd0) begin
						nx_trim = fc_q + 32'd1;
						if (!byte_ok(byte_s1)) nx_tf[0] = 1'b1;
					end
				end else if (ph_q == PH_DESC) begin
					if (byte_s1 != 8'd0 && !byte_ok(byte_s1)) nx_tf[1] = 1'b1;
					if (fc_q < 32'(INT_MAX_BYTES)) begin
						if (cfg.big_endian)
							nx_va = {va_q[55:0], byte_s1};
						else
							nx_va = va_q | (64'(byte_s1) << {fc_q[2:0], 3'b000});
					end
				end
				pad_own = pad_of(nx_own);
				pad_vs = pad_of(nx_vs);

				// settle through every field that is now complete
				if (nx_ph == PH_HEADER && nx_fc >= 32'(HEADER_BYTES)) begin
					rem = nx_len - nx_pos;
					if (nx_own > cfg.name_limit || nx_vs > cfg.data_limit || nx_own > rem) begin
						res_a[0].result_kind = RES_ERROR;
						res_a[0].error_code = ERR_LIMIT;
						res_a[0].offset = nx_rs;
						nx_n = 2'd1;
						nx_ph = PH_DONE;
					end else if (({1'b0, nx_own} + {1'b0, pad_own}) > {1'b0, rem}) begin
						res_a[0].result_kind = RES_ERROR;
						res_a[0].error_code = ERR_TRUNCATED;
						res_a[0].offset = nx_rs;
						nx_n = 2'd1;
						nx_ph = PH_DONE;
					end else begin
						nx_ph = PH_NAME;
						nx_fc = '0;
					end
				end
				if (nx_ph == PH_NAME && nx_fc >= nx_own) begin
					after = nx_pos + pad_own;
					rem = nx_len - after;
					res_a[0].result_kind = RES_ERROR;
					nx_ph = PH_DONE;
					nx_n = 2'd1;
					if (nx_trim == '0 || nx_tf[0]) begin
						res_a[0].error_code = ERR_OWNER;
						res_a[0].offset = nx_rs;
					end else if (nx_vs > rem) begin
						res_a[0].error_code = ERR_TRUNCATED;
						res_a[0].offset = after;
					end else if (({1'b0, nx_vs} + {1'b0, pad_vs}) > {1'b0, rem}) begin
						res_a[0].error_code = ERR_TRUNCATED;
						res_a[0].offset = after + nx_vs;
					end else if (nx_cnt >= cfg.record_limit) begin
						res_a[0].error_code = ERR_LIMIT;
						res_a[0].offset = nx_rs;
					end else begin
						res_a[0] = '0;
						nx_n = 2'd0;
						nx_ph = PH_NAME_PAD;
						nx_fc = '0;
					end
				end
				if (nx_ph == PH_NAME_PAD && nx_fc >= pad_own) begin
					nx_ph = PH_DESC;
					nx_fc = '0;
				end
				if (nx_ph == PH_DESC && nx_fc >= nx_vs) begin
					nx_ph = PH_DESC_PAD;
					nx_fc = '0;
				end
				if (nx_ph == PH_DESC_PAD && nx_fc >= pad_vs) begin
					gnu = nx_trim == 32'd3 && nx_oh[23:0] == OWNER_GNU;
					core = nx_trim == 32'd4 && nx_oh == OWNER_CORE;
					res_a[0].result_kind = RES_NOTE;
					res_a[0].offset = nx_rs;
					res_a[0].note_type = nx_type;
					res_a[0].owner_length = nx_trim;
					res_a[0].descriptor_length = nx_vs;
					if (nx_vs <= 32'(INT_MAX_BYTES) && (gnu || core)) begin
						res_a[0].val_kind = VAL_INT;
						res_a[0].integer_value = nx_va;
					end else if (nx_vs != '0 && !nx_tf[1]) begin
						res_a[0].val_kind = VAL_TEXT;
					end else begin
						res_a[0].val_kind = VAL_BYTES;
					end
					nx_n = 2'd1;
					nx_cnt = nx_cnt + 32'd1;
					begin_note = 1'b1;
				end
			end
		end

		if (begin_note) begin
			rem = nx_len - nx_pos;
			nx_rs = nx_pos;
			nx_fc = '0; nx_hw = '0; nx_own = '0; nx_vs = '0; nx_type = '0;
			nx_oh = '0; nx_trim = '0; nx_tf = '0; nx_va = '0;
			if (rem == '0) begin
				res_a[nx_n[0]] = '0;
				res_a[nx_n[0]].result_kind = RES_FINISH;
				nx_n = nx_n + 2'd1;
				nx_ph = PH_DONE;
			end else if (rem < 32'(HEADER_BYTES)) begin
				res_a[nx_n[0]] = '0;
				res_a[nx_n[0]].result_kind = RES_ERROR;
				res_a[nx_n[0]].error_code = ERR_TRUNCATED;
				res_a[nx_n[0]].offset = nx_pos;
				nx_n = nx_n + 2'd1;
				nx_ph = PH_DONE;
			end else begin
				nx_ph = PH_HEADER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			pos_q <= '0; len_q <= '0; rs_q <= '0; fc_q <= '0; hw_q <= '0;
			own_q <= '0; vs_q <= '0; type_q <= '0; oh_q <= '0; trim_q <= '0;
			tf_q <= '0; va_q <= '0; cnt_q <= '0;
		end else if (fire) begin
			ph_q <= nx_ph;
			pos_q <= nx_pos; len_q <= nx_len; rs_q <= nx_rs; fc_q <= nx_fc;
			hw_q <= nx_hw; own_q <= nx_own; vs_q <= nx_vs; type_q <= nx_type;
			oh_q <= nx_oh; trim_q <= nx_trim; tf_q <= nx_tf; va_q <= nx_va;
			cnt_q <= nx_cnt;
		end
	end

	always_comb begin
		pair.n = nx_n;
		pair.r[0] = res_a[0];
		pair.r[1] = res_a[1];
		pair_valid = fire && nx_n != 2'd0;
	end

	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire && kind_s1 == ITEM_BYTE && ph_q == PH_DONE |=> ph_q == PH_DONE)
		else $error("byte beat left a closed section");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_HEADER || ph_q == PH_NAME || ph_q == PH_NAME_PAD ||
		 ph_q == PH_DESC || ph_q == PH_DESC_PAD) |-> pos_q < len_q)
		else $error("open section with no bytes left");

endmodule

// ===== rtl/enp_out.sv =====
module enp_out (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pair_valid,
	input  enp_pkg::res_pair_t   pair,
	output logic                 can_load,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [199:0]         m_axis_tdata,
	output logic [1:0]           m_axis_tuser,
	output logic                 m_axis_tlast
);
	import enp_pkg::*;

	res_pair_t pair_q;
	logic      valid_q;
	logic      sel_q;
	logic      take;
	logic      done;
	result_t   cur;

	assign cur = sel_q ? pair_q.r[1] : pair_q.r[0];
	assign take = valid_q && m_axis_tready;
	assign done = take && (sel_q || pair_q.n == 2'd1);
	assign can_load = !valid_q || done;

	assign m_axis_tvalid = valid_q;
	assign m_axis_tuser = cur.result_kind;
	assign m_axis_tlast = sel_q || pair_q.n == 2'd1;
	assign m_axis_tdata = {4'b0000, cur.integer_value, cur.val_kind,
		cur.descriptor_length, cur.owner_length, cur.note_type, cur.offset,
		cur.error_code};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= pair_valid;
			sel_q <= 1'b0;
		end else if (take) begin
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && pair_valid) pair_q <= pair;
	end

	a_sel_pair: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && sel_q |-> pair_q.n == 2'd2)
		else $error("second beat shown for a single result");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take && !sel_q && pair_q.n == 2'd2 |=> valid_q && sel_q)
		else $error("second result of a pair lost");

endmodule

// ===== rtl/elf_note_stream_parser.sv =====
// channel   direction  beat contents
// s_axis    in         tuser kind, tdata section_length and data_byte
// m_axis    out        tuser result_kind, tdata result fields, tlast last of item
// cfg       in         cfg_index selects register, cfg_data value
//
// one input beat per cycle while m_axis does not stall; each beat is registered in
// the input register, its parse step runs from there and its results load the output pair
// register. a beat giving two results puts them out as two m_axis beats, tlast on the second.
// config writes are always ready. reset: idle, limits to defaults.
// m_axis stalls back up through the pair register into s_axis_tready.
module elf_note_stream_parser (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [39:0]  s_axis_tdata,  // section_length, data_byte
	input  logic         s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [199:0] m_axis_tdata,  // error_code, offset, note_type, owner_length,
	                                    // descriptor_length, val_kind, integer_value
	output logic [1:0]   m_axis_tuser,  // result_kind
	output logic         m_axis_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import enp_pkg::*;

	cfg_t      cfg;
	res_pair_t pair;
	logic      pair_valid;
	logic      can_load;

	enp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	enp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_kind    (s_axis_tuser),
		.in_length  (s_axis_tdata[31:0]),
		.in_byte    (s_axis_tdata[39:32]),
		.can_load   (can_load),
		.pair_valid (pair_valid),
		.pair       (pair)
	);

	enp_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.pair_valid    (pair_valid),
		.pair          (pair),
		.can_load      (can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== tb/sv/elf_note_stream_parser_test.sv =====
`timescale 1ns / 100ps

module elf_note_stream_parser_test;
	import enp_pkg::*;

	typedef struct {
		res_kind_t   kind;
		err_code_t   code;
		logic [31:0] offset;
		logic [31:0] note_type;
		logic [31:0] owner_len;
		logic [31:0] desc_len;
		val_kind_t   vkind;
		logic [63:0] ival;
		logic        last;
	} note_result_t;

	class note_board;
		logic [31:0] name_limit, data_limit, record_limit;
		logic        big_endian;
		phase_t      phase;
		logic [31:0] pos, sec_len, rec_start, count, hword, owner_size, desc_size;
		logic [31:0] type_word, owner_head, owner_trim, notes;
		logic [1:0]  bad_flags;
		logic [63:0] accum;
		note_result_t expected_results[$];
		int errors, n_results, n_notes, n_finish, n_fail;

		function new();
			name_limit = 32'd4096;
			data_limit = 32'd16777216;
			record_limit = 32'd65536;
			big_endian = 1'b0;
			phase = PH_IDLE;
			pos = '0;
			sec_len = '0;
			notes = '0;
			errors = 0;
			n_results = 0;
			n_notes = 0;
			n_finish = 0;
			n_fail = 0;
		endfunction

		function logic [31:0] pad4(logic [31:0] x);
			return (32'd4 - x % 32'd4) % 32'd4;
		endfunction

		function bit printable(logic [7:0] b);
			return (b >= 8'h20 && b <= 8'h7E) || (b >= 8'h09 && b <= 8'h0D);
		endfunction

		function void write_reg(reg_index_t idx, logic [31:0] val);
			case (idx)
				REG_NAME_LIMIT:   name_limit = val;
				REG_DATA_LIMIT:   data_limit = val;
				REG_RECORD_LIMIT: record_limit = val;
				REG_BIG_ENDIAN:   big_endian = val[0];
			endcase
		endfunction

		function void push(res_kind_t k, err_code_t c, logic [31:0] off, logic [31:0] t,
				logic [31:0] ol, logic [31:0] dl, val_kind_t vk, logic [63:0] iv);
			note_result_t r;
			r.kind = k;
			r.code = c;
			r.offset = off;
			r.note_type = t;
			r.owner_len = ol;
			r.desc_len = dl;
			r.vkind = vk;
			r.ival = iv;
			r.last = 1'b0;
			expected_results.insert(expected_results.size(), r);
		endfunction

		function void fail(err_code_t c, logic [31:0] off);
			push(RES_ERROR, c, off, '0, '0, '0, VAL_INT, '0);
			phase = PH_DONE;
		endfunction

		function void open_note();
			logic [31:0] rem;
			rem = sec_len - pos;
			rec_start = pos;
			count = '0;
			hword = '0;
			owner_size = '0;
			desc_size = '0;
			type_word = '0;
			owner_head = '0;
			owner_trim = '0;
			bad_flags = '0;
			accum = '0;
			if (rem == 0) begin
				push(RES_FINISH, ERR_NONE, '0, '0, '0, '0, VAL_INT, '0);
				phase = PH_DONE;
			end else if (rem < 12) begin
				fail(ERR_TRUNCATED, pos);
			end else begin
				phase = PH_HEADER;
			end
		endfunction

		function void advance();
			logic [63:0] rem64;
			logic [31:0] after, rem;
			bit gnu, core;
			val_kind_t vk;
			logic [63:0] iv;
			forever begin
				case (phase)
					PH_HEADER: begin
						if (count < 12) return;
						rem64 = {32'd0, sec_len - pos};
						if (owner_size > name_limit || desc_size > data_limit ||
								{32'd0, owner_size} > rem64) begin
							fail(ERR_LIMIT, rec_start);
							return;
						end
						if ({32'd0, owner_size} + {32'd0, pad4(owner_size)} > rem64) begin
							fail(ERR_TRUNCATED, rec_start);
							return;
						end
						phase = PH_NAME;
						count = '0;
					end
					PH_NAME: begin
						if (count < owner_size) return;
						if (owner_trim == 0 || bad_flags[0]) begin
							fail(ERR_OWNER, rec_start);
							return;
						end
						after = pos + pad4(owner_size);
						rem = sec_len - after;
						if (desc_size > rem) begin
							fail(ERR_TRUNCATED, after);
							return;
						end
						if ({32'd0, desc_size} + {32'd0, pad4(desc_size)} > {32'd0, rem}) begin
							fail(ERR_TRUNCATED, after + desc_size);
							return;
						end
						if (notes >= record_limit) begin
							fail(ERR_LIMIT, rec_start);
							return;
						end
						phase = PH_NAME_PAD;
						count = '0;
					end
					PH_NAME_PAD: begin
						if (count < pad4(owner_size)) return;
						phase = PH_DESC;
						count = '0;
					end
					PH_DESC: begin
						if (count < desc_size) return;
						phase = PH_DESC_PAD;
						count = '0;
					end
					PH_DESC_PAD: begin
						if (count < pad4(desc_size)) return;
						gnu = owner_trim == 3 && owner_head[23:0] == OWNER_GNU;
						core = owner_trim == 4 && owner_head == OWNER_CORE;
						iv = '0;
						if (desc_size <= 8 && (gnu || core)) begin
							vk = VAL_INT;
							iv = accum;
						end else if (desc_size > 0 && !bad_flags[1]) begin
							vk = VAL_TEXT;
						end else begin
							vk = VAL_BYTES;
						end
						push(RES_NOTE, ERR_NONE, rec_start, type_word, owner_trim,
							desc_size, vk, iv);
						notes++;
						open_note();
					end
					default: return;
				endcase
			end
		endfunction

		function void take(logic [7:0] b);
			logic [31:0] idx;
			idx = count;
			pos++;
			count++;
			case (phase)
				PH_HEADER: begin
					if (big_endian) hword = {hword[23:0], b};
					else hword = hword | ({24'd0, b} << (8 * idx[1:0]));
					if (idx[1:0] == 2'd3) begin
						if (idx == 3) owner_size = hword;
						else if (idx == 7) desc_size = hword;
						else type_word = hword;
						hword = '0;
					end
				end
				PH_NAME: begin
					if (idx < 4) owner_head = owner_head | ({24'd0, b} << (8 * idx));
					if (b != 0) begin
						owner_trim = idx + 32'd1;
						if (!printable(b)) bad_flags[0] = 1'b1;
					end
				end
				PH_DESC: begin
					if (b != 0 && !printable(b)) bad_flags[1] = 1'b1;
					if (idx < 8) begin
						if (big_endian) accum = {accum[55:0], b};
						else accum = accum | ({56'd0, b} << (8 * idx));
					end
				end
				default: ;
			endcase
		endfunction

		function void note_input(item_kind_t k, logic [31:0] len, logic [7:0] b);
			int first;
			first = expected_results.size();
			if (k == ITEM_START) begin
				pos = '0;
				notes = '0;
				sec_len = len;
				rec_start = '0;
				if (len > data_limit) begin
					fail(ERR_LIMIT, '0);
				end else begin
					open_note();
					advance();
				end
			end else begin
				if (phase == PH_IDLE || phase == PH_DONE) return;
				take(b);
				advance();
			end
			if (expected_results.size() > first)
				expected_results[expected_results.size() - 1].last = 1'b1;
		endfunction

		function void diff(string field, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				$error("%s mismatch: expected %0h, got %0h", field, exp, act);
				errors++;
			end
		endfunction

		function void check_result(logic [1:0] user, logic [199:0] data, logic last);
			note_result_t e;
			n_results++;
			if (expected_results.size() == 0) begin
				$error("unexpected result beat: kind %0d data %0h", user, data);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			case (e.kind)
				RES_NOTE:   n_notes++;
				RES_FINISH: n_finish++;
				default:    n_fail++;
			endcase
			diff("result_kind", 64'(e.kind), 64'(user));
			diff("error_code", 64'(e.code), 64'(data[1:0]));
			diff("offset", 64'(e.offset), 64'(data[33:2]));
			diff("note_type", 64'(e.note_type), 64'(data[65:34]));
			diff("owner_length", 64'(e.owner_len), 64'(data[97:66]));
			diff("descriptor_length", 64'(e.desc_len), 64'(data[129:98]));
			diff("val_kind", 64'(e.vkind), 64'(data[131:130]));
			diff("integer_value", e.ival, data[195:132]);
			diff("padding", 64'd0, 64'(data[199:196]));
			diff("last", 64'(e.last), 64'(last));
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [39:0]  s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [199:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [31:0]  cfg_data;

	note_board board;
	logic [7:0] sec_bytes[$];
	bit   quiet;
	bit   hold_req;
	int   items;

	elf_note_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 0;
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
			if (hold_req && !held) begin
				held = 1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= quiet || $urandom_range(99) >= 6;
			end
		end
	end

	task automatic send_beat(item_kind_t k, logic [31:0] len, logic [7:0] b);
		while (!quiet && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= k;
		s_axis_tdata <= {b, len};
		do @(posedge clk); while (!s_axis_tready);
		board.note_input(k, len, b);
		items++;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.expected_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(logic [31:0] nl, logic [31:0] dl, logic [31:0] rl, logic be);
		drain();
		write_reg(REG_NAME_LIMIT, nl);
		write_reg(REG_DATA_LIMIT, dl);
		write_reg(REG_RECORD_LIMIT, rl);
		write_reg(REG_BIG_ENDIAN, {31'd0, be});
	endtask

	task automatic add_byte(logic [7:0] b);
		sec_bytes.insert(sec_bytes.size(), b);
	endtask

	task automatic put_word(logic [31:0] w);
		if (board.big_endian) begin
			add_byte(w[31:24]);
			add_byte(w[23:16]);
			add_byte(w[15:8]);
			add_byte(w[7:0]);
		end else begin
			add_byte(w[7:0]);
			add_byte(w[15:8]);
			add_byte(w[23:16]);
			add_byte(w[31:24]);
		end
	endtask

	function automatic logic [7:0] text_byte();
		if ($urandom_range(9) == 0) return 8'h00;
		if ($urandom_range(9) == 0) return 8'h09 + 8'($urandom_range(4));
		return 8'h20 + 8'($urandom_range(94));
	endfunction

	// owner sel: 0 GNU nul, 1 CORE, 2 text, 3 random, 4 empty, 5 GNU unterminated
	task automatic add_note(int sel);
		logic [7:0] owner[$];
		int dsz, extra;
		bit txt;
		owner = {};
		case (sel)
			0: owner = {8'h47, 8'h4E, 8'h55, 8'h00};
			1: begin
				owner = {8'h43, 8'h4F, 8'h52, 8'h45};
				extra = $urandom_range(2);
				repeat (extra) owner.insert(owner.size(), 8'h00);
			end
			2: begin
				repeat ($urandom_range(1, 9))
					owner.insert(owner.size(), 8'h20 + 8'($urandom_range(94)));
				repeat ($urandom_range(2)) owner.insert(owner.size(), 8'h00);
			end
			3: repeat ($urandom_range(6)) owner.insert(owner.size(), 8'($urandom_range(255)));
			5: owner = {8'h47, 8'h4E, 8'h55};
			default: ;
		endcase
		dsz = (sel == 0 || sel == 1 || sel == 5) && $urandom_range(1) ?
			$urandom_range(8) : $urandom_range(14);
		txt = 1'($urandom_range(1));
		put_word(owner.size());
		put_word(dsz);
		put_word($urandom());
		foreach (owner[i]) add_byte(owner[i]);
		repeat (board.pad4(owner.size())) add_byte(8'($urandom_range(255)));
		repeat (dsz) add_byte(txt ? text_byte() : 8'($urandom_range(255)));
		repeat (board.pad4(dsz)) add_byte(8'($urandom_range(255)));
	endtask

	// flaw: 0 clean, 1 short length, 2 trailing junk, 3 corrupted byte
	task automatic send_section(int notes, int flaw, int sel);
		int total, k;
		sec_bytes = {};
		for (int i = 0; i < notes; i++) add_note(sel >= 0 ? sel : $urandom_range(5));
		if (flaw == 2) repeat ($urandom_range(1, 14)) add_byte(8'($urandom_range(255)));
		if (flaw == 3 && sec_bytes.size() > 0) begin
			k = $urandom_range(sec_bytes.size() - 1);
			sec_bytes[k] = 8'($urandom_range(255));
		end
		total = sec_bytes.size();
		if (flaw == 1) total = total - $urandom_range(1, 8);
		send_beat(ITEM_START, total, '0);
		foreach (sec_bytes[i]) send_beat(ITEM_BYTE, '0, sec_bytes[i]);
	endtask

	task automatic random_traffic(int count);
		int stop, r;
		stop = items + count;
		while (items < stop) begin
			r = $urandom_range(99);
			if (r < 70) send_section($urandom_range(1, 3), 0, -1);
			else if (r < 88) send_section($urandom_range(1, 3), $urandom_range(1, 3), -1);
			else if (r < 94) send_beat(ITEM_START, $urandom(), '0);
			else repeat ($urandom_range(1, 5))
				send_beat(ITEM_BYTE, '0, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		board = new();
		items = 0;
		quiet = 0;
		hold_req = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tuser = ITEM_START;
		s_axis_tdata = 0;
		cfg_valid = 0;
		cfg_index = REG_NAME_LIMIT;
		cfg_data = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray bytes while idle, empty section, over-long, short section
		send_beat(ITEM_BYTE, '0, 8'hFF);
		send_beat(ITEM_START, '0, '0);
		send_beat(ITEM_START, 32'd16777217, '0);
		send_beat(ITEM_START, 32'd5, '0);
		send_section(1, 0, 0);
		send_section(1, 0, 1);
		send_section(1, 0, 2);
		send_section(1, 0, 3);
		send_section(1, 0, 4);
		send_section(1, 1, 5);
		send_beat(ITEM_START, 32'd40, '0);
		send_beat(ITEM_BYTE, '0, 8'h00);
		send_section(2, 2, -1);

		set_limits(32'd4096, 32'd16777216, 32'd65536, 1'b1);
		send_section(1, 0, 0);
		send_section(1, 0, 1);
		random_traffic(220);
		hold_req = 1;
		random_traffic(220);

		set_limits(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
		quiet = 1;
		send_beat(ITEM_START, 32'hFFFFFFFF, '0);
		random_traffic(250);
		quiet = 0;

		set_limits(32'd3, 32'd40, 32'd2, 1'b1);
		random_traffic(250);

		set_limits('0, '0, '0, 1'b0);
		send_beat(ITEM_START, '0, '0);
		send_section(1, 0, -1);

		set_limits(32'd8, 32'd200, 32'd1, 1'b0);
		random_traffic(220);

		set_limits(32'd4096, 32'd16777216, 32'd65536, 1'b1);
		random_traffic(160);

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d input beats, %0d result beats: %0d notes, %0d finished, %0d errors",
			items, board.n_results, board.n_notes, board.n_finish, board.n_fail);
		$display("limit settings from zero to all ones, both byte orders, long output stall");
		if (board.errors == 0 && board.expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/enp_pkg.sv
rtl/enp_cfg.sv
rtl/enp_core.sv
rtl/enp_out.sv
rtl/elf_note_stream_parser.sv
tb/sv/elf_note_stream_parser_test.sv
